FILE: rtl/missing_packet_request_planner_top_defines.svh
// Assertion macros for the top-level RTL file of the missing-packet request planner.
`ifndef MISSING_PACKET_REQUEST_PLANNER_TOP_DEFINES_SVH
`define MISSING_PACKET_REQUEST_PLANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mprp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mprp assertion failed");

`endif

FILE: rtl/mprp_pkg.sv
`default_nettype none

package mprp_pkg;

    localparam int MAX_PACKETS_DEFAULT = 4096;
    localparam int TOTAL_W             = 13;
    localparam int PKT_W               = 16;

    // Command carried in the input tuser bit.
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_PLAN   = 1'b1;

    // Arrival status codes.
    localparam logic [1:0] ST_STORED    = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_DAMAGED   = 2'd3;

    // Register index of total_packets (paddr bit 2).
    localparam logic REG_TOTAL_IDX = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ARR,
        S_WALK,
        S_HOLD
    } state_t;

    // Position of the map walk within the planning rules.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_FIRST,
        PH_GOT,
        PH_MISS
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/mprp_ram.sv
`default_nettype none

module mprp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port; the read data register only changes on a read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/missing_packet_request_planner_top.sv
// Missing-packet request planner.
// Input stream (s_tvalid/s_tready/s_tdata/s_tuser): s_tuser is the command, 0 for a
// packet arrival and 1 for a request to plan the next retransmission. An arrival beat
// carries the packet number and its damaged flag in s_tdata.
// Output stream (m_tvalid/m_tready/m_tdata): one result beat per input beat, holding
// the arrival status, the all-received flag and the request start and count.
// Configuration: an APB port with the total_packets register at byte address 0.
// The received-bit map lives in a single-port RAM with one bit per packet.
// An arrival reads the map bit in the accept cycle and, for a stored packet, sets it in
// the next, when the result is loaded into the output register; the next beat may be
// accepted in the cycle after that.
// A plan walks the map one bit per cycle through the RAM read port, ending early once
// the span stops growing.
// After reset the map is cleared by a pass over all MAX_PACKETS entries, during which
// s_tready stays low; configuration writes are taken throughout.
// The output register parts the two sides: a new beat is accepted while a result
// waits, and when the receiver stalls a finished result is parked in a holding
// register until the output register frees, with s_tready low meanwhile.

`default_nettype none

`include "missing_packet_request_planner_top_defines.svh"

module missing_packet_request_planner_top #(
    parameter int MAX_PACKETS = mprp_pkg::MAX_PACKETS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: [15:0] packet_number, [16] packet_damaged, [23:17] zero
    input  wire logic [23:0] s_tdata,
    // s_tuser: [0] command
    input  wire logic [0:0]  s_tuser,
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: [1:0] arrival_status, [2] all_received, [15:3] request_start,
    // [28:16] request_count, [31:29] zero
    output logic      [31:0] m_tdata
);

    localparam int AW = $clog2(MAX_PACKETS);
    localparam int TW = mprp_pkg::TOTAL_W;
    localparam int PW = mprp_pkg::PKT_W;

    mprp_pkg::state_t state_reg, state_next;
    mprp_pkg::phase_t phase_reg, phase_next;

    logic [TW-1:0] total_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [PW-1:0] pk_reg, pk_next;
    logic          dmg_reg, dmg_next;
    logic [TW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [TW-1:0] start_reg, start_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] got_reg, got_next;
    logic [TW-1:0] miss_reg, miss_next;

    // Holding register for a result finished while the output register is full.
    logic [1:0]    hold_status_reg, hold_status_next;
    logic          hold_all_reg, hold_all_next;
    logic [TW-1:0] hold_start_reg, hold_start_next;
    logic [TW-1:0] hold_count_reg, hold_count_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_all_reg, out_all_next;
    logic [TW-1:0] out_start_reg, out_start_next;
    logic [TW-1:0] out_count_reg, out_count_next;

    logic          ram_we, ram_re, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    logic [TW-1:0] eff_total;
    logic          out_free;
    logic          cfg_write;

    // Result being finished this cycle.
    logic          fin;
    logic [1:0]    res_status;
    logic          res_all;
    logic [TW-1:0] res_start, res_count;
    logic [TW-1:0] bit_idx;
    logic          got_lt_miss;
    logic [TW-1:0] got_plus_miss;

    // A total above the map capacity saturates to the capacity.
    assign eff_total = (32'(total_reg) > 32'(MAX_PACKETS)) ? TW'(MAX_PACKETS) : total_reg;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == mprp_pkg::REG_TOTAL_IDX) ? {19'b0, total_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == mprp_pkg::REG_TOTAL_IDX))
        begin
            total_reg <= pwdata[TW-1:0];
        end
    end

    assign s_tready = (state_reg == mprp_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, out_count_reg, out_start_reg, out_all_reg, out_status_reg};
    assign out_free = !m_valid_reg || m_tready;

    // The compare and add used by the PH_MISS step and the end-of-map result.
    assign got_lt_miss   = (got_reg < miss_reg);
    assign got_plus_miss = got_reg + miss_reg;
    assign bit_idx       = iss_reg - TW'(1);

    mprp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PACKETS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mprp_pkg::S_CLEAR;
            phase_reg   <= mprp_pkg::PH_SKIP;
            clr_reg     <= '0;
            iss_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            clr_reg     <= clr_next;
            iss_reg     <= iss_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pk_reg          <= pk_next;
        dmg_reg         <= dmg_next;
        start_reg       <= start_next;
        cnt_reg         <= cnt_next;
        got_reg         <= got_next;
        miss_reg        <= miss_next;
        hold_status_reg <= hold_status_next;
        hold_all_reg    <= hold_all_next;
        hold_start_reg  <= hold_start_next;
        hold_count_reg  <= hold_count_next;
        out_status_reg  <= out_status_next;
        out_all_reg     <= out_all_next;
        out_start_reg   <= out_start_next;
        out_count_reg   <= out_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        clr_next         = clr_reg;
        pk_next          = pk_reg;
        dmg_next         = dmg_reg;
        iss_next         = iss_reg;
        pend_next        = pend_reg;
        start_next       = start_reg;
        cnt_next         = cnt_reg;
        got_next         = got_reg;
        miss_next        = miss_reg;
        hold_status_next = hold_status_reg;
        hold_all_next    = hold_all_reg;
        hold_start_next  = hold_start_reg;
        hold_count_next  = hold_count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_all_next     = out_all_reg;
        out_start_next   = out_start_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_addr         = AW'(iss_reg);
        ram_wdata        = 1'b0;
        fin              = 1'b0;
        res_status       = mprp_pkg::ST_STORED;
        res_all          = 1'b0;
        res_start        = '0;
        res_count        = '0;

        unique case (state_reg)
            mprp_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_PACKETS - 1))
                begin
                    state_next = mprp_pkg::S_IDLE;
                end
            end

            mprp_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == mprp_pkg::CMD_ARRIVE)
                    begin
                        pk_next    = s_tdata[PW-1:0];
                        dmg_next   = s_tdata[PW];
                        ram_re     = 1'b1;
                        ram_addr   = AW'(s_tdata[PW-1:0]);
                        state_next = mprp_pkg::S_ARR;
                    end
                    else
                    begin
                        iss_next   = '0;
                        pend_next  = 1'b0;
                        phase_next = mprp_pkg::PH_SKIP;
                        start_next = '0;
                        cnt_next   = '0;
                        got_next   = '0;
                        miss_next  = '0;
                        state_next = mprp_pkg::S_WALK;
                    end
                end
            end

            mprp_pkg::S_ARR:
            begin
                fin = 1'b1;
                priority if (pk_reg >= {3'b0, eff_total})
                begin
                    res_status = mprp_pkg::ST_RANGE;
                end
                else if (ram_rdata)
                begin
                    res_status = mprp_pkg::ST_DUPLICATE;
                end
                else if (dmg_reg)
                begin
                    res_status = mprp_pkg::ST_DAMAGED;
                end
                else
                begin
                    res_status = mprp_pkg::ST_STORED;
                    ram_we     = 1'b1;
                    ram_addr   = AW'(pk_reg);
                    ram_wdata  = 1'b1;
                end
            end

            mprp_pkg::S_WALK:
            begin
                if (pend_reg)
                begin
                    // Classify the bit of packet bit_idx read in the previous cycle.
                    unique case (phase_reg)
                        mprp_pkg::PH_SKIP:
                        begin
                            if (!ram_rdata)
                            begin
                                start_next = bit_idx;
                                miss_next  = TW'(1);
                                phase_next = mprp_pkg::PH_FIRST;
                            end
                        end
                        mprp_pkg::PH_FIRST:
                        begin
                            if (!ram_rdata)
                            begin
                                miss_next = miss_reg + TW'(1);
                            end
                            else
                            begin
                                cnt_next   = miss_reg;
                                got_next   = TW'(1);
                                phase_next = mprp_pkg::PH_GOT;
                            end
                        end
                        mprp_pkg::PH_GOT:
                        begin
                            if (ram_rdata)
                            begin
                                got_next = got_reg + TW'(1);
                            end
                            else
                            begin
                                miss_next  = miss_reg + TW'(1);
                                phase_next = mprp_pkg::PH_MISS;
                            end
                        end
                        mprp_pkg::PH_MISS:
                        begin
                            if (!ram_rdata)
                            begin
                                miss_next = miss_reg + TW'(1);
                            end
                            else if (got_lt_miss)
                            begin
                                cnt_next   = got_plus_miss;
                                got_next   = got_reg + TW'(1);
                                phase_next = mprp_pkg::PH_GOT;
                            end
                            else
                            begin
                                // The span stops short of this received run.
                                fin       = 1'b1;
                                res_start = start_reg;
                                res_count = cnt_reg;
                            end
                        end
                        default:
                        begin
                            phase_next = mprp_pkg::PH_SKIP;
                        end
                    endcase
                end
                else if (iss_reg >= eff_total)
                begin
                    // End of the map reached with every bit classified.
                    fin       = 1'b1;
                    res_start = start_reg;
                    unique case (phase_reg)
                        mprp_pkg::PH_SKIP:
                        begin
                            res_all   = 1'b1;
                            res_start = '0;
                        end
                        mprp_pkg::PH_FIRST:
                        begin
                            res_count = miss_reg;
                        end
                        mprp_pkg::PH_GOT:
                        begin
                            res_count = cnt_reg;
                        end
                        mprp_pkg::PH_MISS:
                        begin
                            res_count = got_lt_miss ? got_plus_miss : cnt_reg;
                        end
                        default:
                        begin
                            res_count = cnt_reg;
                        end
                    endcase
                end

                if (!fin && (iss_reg < eff_total))
                begin
                    ram_re    = 1'b1;
                    ram_addr  = AW'(iss_reg);
                    iss_next  = iss_reg + TW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            mprp_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = hold_status_reg;
                    out_all_next    = hold_all_reg;
                    out_start_next  = hold_start_reg;
                    out_count_next  = hold_count_reg;
                    state_next      = mprp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mprp_pkg::S_IDLE;
            end
        endcase

        // A finished result goes straight out when it can, else it is parked.
        if (fin)
        begin
            if (out_free)
            begin
                m_valid_next    = 1'b1;
                out_status_next = res_status;
                out_all_next    = res_all;
                out_start_next  = res_start;
                out_count_next  = res_count;
                state_next      = mprp_pkg::S_IDLE;
            end
            else
            begin
                hold_status_next = res_status;
                hold_all_next    = res_all;
                hold_start_next  = res_start;
                hold_count_next  = res_count;
                state_next       = mprp_pkg::S_HOLD;
            end
        end
    end

    `MPRP_ASSERT_SAME(a_all_received_empty, clk, rst_n,
        m_valid_reg && out_all_reg, (out_start_reg == '0) && (out_count_reg == '0))
    `MPRP_ASSERT_SAME(a_span_within_total, clk, rst_n,
        m_valid_reg,
        ({1'b0, out_start_reg} + {1'b0, out_count_reg}) <= {1'b0, eff_total})
    `MPRP_ASSERT_SAME(a_mark_only_new, clk, rst_n,
        ram_we && (state_reg == mprp_pkg::S_ARR), !ram_rdata && ram_wdata && !dmg_reg)
    `MPRP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_tvalid && s_tready, state_reg != mprp_pkg::S_IDLE)

endmodule

`default_nettype wire

FILE: bench/tb_missing_packet_request_planner_top.sv
`timescale 1ns / 100ps

// Stand-alone bench for the missing-packet request planner. It drives the input stream,
// the output stream back-pressure and the APB register port, predicts every result beat
// from its own copy of the received map and the transfer size, and compares the beats
// that come out against the oldest prediction.
module tb_missing_packet_request_planner_top;

    // The block is built with its default capacity, so the bench mirrors that.
    localparam int CAPACITY = mprp_pkg::MAX_PACKETS_DEFAULT;

    // Byte addresses on the APB port. Only index 0 exists; index 1 is written to
    // show that a write to an unknown register leaves the transfer size alone.
    localparam logic [2:0] ADDR_TOTAL  = {mprp_pkg::REG_TOTAL_IDX, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    // Cycles without any accepted beat before the run is abandoned. The clearing pass
    // after reset and a plan over a full map each cover the whole map, and a receiver
    // stall may sit on top of either, so the limit is set above both.
    localparam int QUIET_LIMIT = 40000;

    // Cycles allowed after the last result in case the block puts out anything more.
    localparam int TAIL_CYCLES = 20;

    localparam int NUM_PHASES = 13;

    // One result beat, split into its fields.
    typedef struct {
        logic [1:0]  status;
        logic        all_rcvd;
        logic [12:0] start;
        logic [12:0] count;
    } beat_result_t;

    // Keeps the expected view of the received map and the transfer size, works out the
    // result of every accepted input beat and checks the result beats in order.
    class request_plan_checker;
        bit           received [CAPACITY];
        logic [12:0]  total_reg;
        beat_result_t pending[$];
        int           errors;

        function new();
            total_reg = '0;
            errors    = 0;
            foreach (received[j])
                received[j] = 1'b0;
        endfunction

        function void set_total(logic [12:0] value);
            total_reg = value;
        endfunction

        // A size beyond the capacity of the map behaves as the capacity.
        function int effective_total();
            return (int'(total_reg) > CAPACITY) ? CAPACITY : int'(total_reg);
        endfunction

        function void note_beat(logic cmd, logic [15:0] pkt, logic damaged);
            beat_result_t res;
            int n;
            int i;
            int cnt;
            int got;
            int miss;
            n            = effective_total();
            res.status   = mprp_pkg::ST_STORED;
            res.all_rcvd = 1'b0;
            res.start    = '0;
            res.count    = '0;
            if (cmd == mprp_pkg::CMD_ARRIVE)
            begin
                // Range first, then duplicate, then damage.
                if (int'(pkt) >= n)
                    res.status = mprp_pkg::ST_RANGE;
                else if (received[pkt])
                    res.status = mprp_pkg::ST_DUPLICATE;
                else if (damaged)
                    res.status = mprp_pkg::ST_DAMAGED;
                else
                    received[pkt] = 1'b1;
            end
            else
            begin
                i   = 0;
                got = 0;
                while (i < n && received[i])
                    i++;
                if (i == n)
                begin
                    res.all_rcvd = 1'b1;
                end
                else
                begin
                    res.start = i[12:0];
                    cnt       = 0;
                    while (i < n && !received[i])
                    begin
                        cnt++;
                        i++;
                    end
                    miss = cnt;
                    // Grow over a received run and the gap after it only while the
                    // span still holds fewer received packets than missing ones.
                    while (i < n)
                    begin
                        while (i < n && received[i])
                        begin
                            got++;
                            i++;
                        end
                        if (i == n)
                            break;
                        while (i < n && !received[i])
                        begin
                            miss++;
                            i++;
                        end
                        if (got < miss)
                            cnt = got + miss;
                        else
                            break;
                    end
                    res.count = cnt[12:0];
                end
            end
            pending.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_beat(logic [31:0] word);
            beat_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result beat 0x%08h with nothing expected", word));
            end
            else
            begin
                want = pending.pop_front();
                if (word[1:0] !== want.status)
                    report($sformatf("arrival_status got %0d expected %0d",
                                     word[1:0], want.status));
                if (word[2] !== want.all_rcvd)
                    report($sformatf("all_received got %0d expected %0d",
                                     word[2], want.all_rcvd));
                if (word[15:3] !== want.start)
                    report($sformatf("request_start got %0d expected %0d",
                                     word[15:3], want.start));
                if (word[28:16] !== want.count)
                    report($sformatf("request_count got %0d expected %0d",
                                     word[28:16], want.count));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata: [15:0] packet_number, [16] packet_damaged, [23:17] zero
    logic [23:0] s_tdata;
    // s_tuser: [0] command
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata: [1:0] arrival_status, [2] all_received, [15:3] request_start,
    // [28:16] request_count, [31:29] zero
    logic [31:0] m_tdata;

    request_plan_checker sb;

    // Set for the closing phase, in which neither side idles.
    bit calm_tail   = 1'b0;
    int quiet_count = 0;

    missing_packet_request_planner_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Presents one input beat and returns at the edge at which it is taken. The beat is
    // then handed to the checker, which sees beats in the order the block takes them.
    task automatic send_beat(input logic cmd, input logic [15:0] pkt, input logic damaged);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, damaged, pkt};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_beat(cmd, pkt, damaged);
    endtask

    task automatic idle_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the input back until every predicted result has come out, which leaves the
    // block idle since each input beat yields exactly one result beat.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the edge where
    // pready is seen high during the access.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TOTAL)
            sb.set_total(data[12:0]);
        @(posedge clk);
    endtask

    task automatic change_total(input logic [31:0] data);
        wait_drained();
        apb_write(ADDR_TOTAL, data);
    endtask

    // The receiver alternates at random between runs of readiness and stalls,
    // and stays ready once the closing phase has begun.
    initial
    begin : receiver
        int hold;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm_tail)
            begin
                m_tready <= 1'b1;
                hold = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 13);
            end
            else
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 20);
            end
            repeat (hold - 1) @(posedge clk);
        end
    end

    // Every result beat taken by the receiver is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_beat(m_tdata);
    end

    // Watchdog: a run of cycles in which neither stream moves a beat means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
        begin
            quiet_count <= 0;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          phase_total [NUM_PHASES];
        int          p;
        int          k;
        int          n;
        int          r;
        int          items;
        int          gap_pct;
        logic [15:0] pkt;
        logic        damaged;
        logic [31:0] word;

        sb = new();

        // The transfer sizes of the random phases. Small sizes carry most of the beats
        // because a plan walks up to the whole transfer; the extremes are here too,
        // including a value above the capacity, an empty transfer and a single packet.
        phase_total = '{16, 64, 8191, 120, 200, 4096, 300, 0, 450, 600, 1, 800, 4095};

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tuser  <= mprp_pkg::CMD_ARRIVE;
        s_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first beats wait out the clearing pass. With the size still
        // at its reset value of zero the transfer is empty: a plan reports everything as
        // received and every arrival is out of range.
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'hFFFF, 1'b1);

        // A size above the capacity saturates, so the last packet of the map is in range
        // and the one after it is not.
        change_total(32'h0000_1FFF);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd4095, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd4096, 1'b0);
        send_beat(mprp_pkg::CMD_PLAN, 16'hFFFF, 1'b1);

        // A damaged new packet is refused, but a damaged copy of a packet already held
        // counts as a duplicate because the duplicate test comes first.
        change_total(32'd4);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd0, 1'b1);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd0, 1'b1);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd2, 1'b0);
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);

        // A write to the unused register must not disturb the transfer size.
        wait_drained();
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);

        // Shrinking the size keeps the map: packet 0 is still held.
        change_total(32'd1);
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd1, 1'b0);

        // Growing it to the full capacity brings back the bits stored earlier.
        change_total(32'd4096);
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);
        send_beat(mprp_pkg::CMD_ARRIVE, 16'd4000, 1'b0);
        send_beat(mprp_pkg::CMD_PLAN, 16'd0, 1'b0);

        // Random phases. Most beats are arrivals of in-range packets, so the map fills
        // with scattered runs and the plans see many gaps; a share are plans and the
        // rest are arbitrary packet numbers, mostly out of range.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            word       = $urandom();
            word[12:0] = phase_total[p][12:0];
            change_total(word);
            if ($urandom_range(0, 1) == 1)
                apb_write(ADDR_UNUSED, $urandom());
            n = sb.effective_total();

            if (p == NUM_PHASES - 1)
                calm_tail = 1'b1;
            if (calm_tail || p % 3 == 0)
                gap_pct = 0;
            else if (p % 3 == 1)
                gap_pct = 20;
            else
                gap_pct = 50;

            if (n == 0)
                items = 20;
            else if (n > 1000)
                items = 40;
            else
                items = 88;

            for (k = 0; k < items; k++)
            begin
                // Now and then the sender holds back until all results are home.
                if (p % 4 == 1 && k == items / 2)
                    wait_drained();
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                    idle_input($urandom_range(1, 13));

                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    send_beat(mprp_pkg::CMD_PLAN, 16'($urandom()), 1'($urandom()));
                end
                else if (r < 90 && n > 0)
                begin
                    pkt     = 16'($urandom_range(0, n - 1));
                    damaged = ($urandom_range(0, 9) == 0);
                    send_beat(mprp_pkg::CMD_ARRIVE, pkt, damaged);
                end
                else
                begin
                    send_beat(mprp_pkg::CMD_ARRIVE, 16'($urandom()), 1'($urandom()));
                end
            end
        end

        // All stimulus is in: wait for the last results, then a short tail so that a
        // stray extra beat would still be caught.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
